FILE: hdl/aabb_pkg.sv
// Shared types, constants and the saturation helper of the box collision resolver.
`timescale 1ns / 1ps

package aabb_pkg;

    // Field widths
    localparam int COORD_BITS = 24;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int SLOT_BITS  = 4;
    localparam int COUNT_BITS = 5;
    // Sum of corner, size and shift
    localparam int EXT_BITS   = COORD_BITS + 2;
    // Penetration depths and shift candidates before saturation
    localparam int WIDE_BITS  = COORD_BITS + 4;

    // Opcodes of an input item
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    // Kinds of a result item
    localparam logic KIND_CONTACT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Register word index (paddr[2])
    localparam logic REG_ACTIVE_COUNT = 1'b0;

    // Saturation bounds in the wide format
    localparam logic signed [WIDE_BITS-1:0] COORD_MAX_W =
        {{(WIDE_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [WIDE_BITS-1:0] COORD_MIN_W =
        {{(WIDE_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    // Input item
    typedef struct packed {
        logic                         opcode;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] off_x;
        logic signed [COORD_BITS-1:0] off_y;
        logic [SIZE_BITS-1:0]         size_x;
        logic [SIZE_BITS-1:0]         size_y;
        logic                         trigger;
    } t_item;

    // Result item
    typedef struct packed {
        logic                         kind;
        logic [SLOT_BITS-1:0]         other_slot;
        logic                         solid;
        logic signed [COORD_BITS-1:0] shift_x;
        logic signed [COORD_BITS-1:0] shift_y;
        logic                         last;
    } t_result;

    // Classified command handed from front to back
    typedef enum logic [1:0] {
        CK_LOAD,
        CK_SCAN,
        CK_SUMMARY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                    kind;
        logic [SLOT_BITS-1:0]         slot;
        logic [COUNT_BITS-1:0]        n;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [SIZE_BITS-1:0]         w;
        logic [SIZE_BITS-1:0]         h;
        logic                         trg;
    } t_cmd;

    // One stored box
    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [SIZE_BITS-1:0]         w;
        logic [SIZE_BITS-1:0]         h;
        logic                         trg;
    } t_box;

    // Clamp a wide value to the signed coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] r;
        if (v > COORD_MAX_W) begin
            r = COORD_MAX_W[COORD_BITS-1:0];
        end else if (v < COORD_MIN_W) begin
            r = COORD_MIN_W[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/aabb_fifo.sv
// Small register queue used between front and back and on the result side.
`timescale 1ns / 1ps

module aabb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: hdl/aabb_fe.sv
// Front part: accepts items, forms box corners and classifies each item.
`timescale 1ns / 1ps

module aabb_fe #(
    parameter int MAX_BOXES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  aabb_pkg::t_item                     i_item,
    input  logic [aabb_pkg::COUNT_BITS-1:0]     i_active_count,
    output logic                                o_cmd_push,
    output aabb_pkg::t_cmd                      o_cmd,
    input  logic                                i_cmd_full
);

    logic                                     r_vld, n_vld;
    aabb_pkg::t_cmd                           r_cmd, n_cmd;
    logic                                     accept, keep;
    logic [aabb_pkg::COUNT_BITS-1:0]          lim;
    logic signed [aabb_pkg::WIDE_BITS-1:0]    sum_x, sum_y;

    // One item held; it moves on whenever the command queue has room
    assign o_full     = r_vld & i_cmd_full;
    assign accept     = i_push & ~o_full;
    assign o_cmd_push = r_vld & ~i_cmd_full;
    assign o_cmd      = r_cmd;

    // Effective count of active slots
    assign lim = (32'(i_active_count) > MAX_BOXES) ?
                 aabb_pkg::COUNT_BITS'(MAX_BOXES) : i_active_count;

    assign sum_x = aabb_pkg::WIDE_BITS'(i_item.pos_x) + aabb_pkg::WIDE_BITS'(i_item.off_x);
    assign sum_y = aabb_pkg::WIDE_BITS'(i_item.pos_y) + aabb_pkg::WIDE_BITS'(i_item.off_y);

    // Classify: valid load, dropped load, scan, or summary only
    always_comb begin
        n_cmd.slot = i_item.slot;
        n_cmd.n    = lim;
        n_cmd.cx   = aabb_pkg::sat_coord(sum_x);
        n_cmd.cy   = aabb_pkg::sat_coord(sum_y);
        n_cmd.w    = i_item.size_x;
        n_cmd.h    = i_item.size_y;
        n_cmd.trg  = i_item.trigger;
        keep       = 1'b1;
        if (i_item.opcode == aabb_pkg::OP_LOAD) begin
            n_cmd.kind = aabb_pkg::CK_LOAD;
            keep       = (32'(i_item.slot) < MAX_BOXES);
        end else if (aabb_pkg::COUNT_BITS'(i_item.slot) < lim) begin
            n_cmd.kind = aabb_pkg::CK_SCAN;
        end else begin
            n_cmd.kind = aabb_pkg::CK_SUMMARY;
        end
    end

    always_comb begin
        if (accept) begin
            n_vld = keep;
        end else if (o_cmd_push) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: hdl/aabb_be.sv
// Back part: box memory and the sequencer that scans later slots and pushes results.
`timescale 1ns / 1ps

module aabb_be #(
    parameter int MAX_BOXES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aabb_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output aabb_pkg::t_result o_res,
    output logic              o_res_push,
    input  logic              i_res_full
);

    localparam int AW  = $clog2(MAX_BOXES);
    localparam int CB  = aabb_pkg::COORD_BITS;
    localparam int EB  = aabb_pkg::EXT_BITS;
    localparam int WB  = aabb_pkg::WIDE_BITS;
    localparam int NB  = aabb_pkg::COUNT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACAP,
        ST_SUMS,
        ST_OVL,
        ST_ABS,
        ST_UPD,
        ST_SUM
    } t_state;

    t_state                  r_state, n_state;
    logic [NB-1:0]           r_j, n_j, r_n, n_n, j_inc;
    logic signed [CB-1:0]    r_sx, r_sy, n_sx, n_sy, upd_x, upd_y;
    logic                    last_j;

    // Box memory, one read port with registered data
    aabb_pkg::t_box          r_mem [MAX_BOXES];
    aabb_pkg::t_box          r_rd_box, wr_box;
    logic [AW-1:0]           rd_addr;
    logic                    mem_we;

    // Datapath registers
    logic signed [EB-1:0]    r_acx, r_acxw, r_acy, r_acyh;
    logic                    r_atrg, r_btrg;
    logic signed [EB-1:0]    r_ax, r_axw, r_bx, r_bxw;
    logic signed [EB-1:0]    r_ay, r_ayh, r_by, r_byh;
    logic signed [WB-1:0]    r_ox, r_oy, abs_ox, abs_oy;
    logic                    r_hit, r_solid, r_xle;
    logic signed [CB-1:0]    r_nsx, r_nsy;

    assign j_inc  = r_j + 1'b1;
    assign last_j = (j_inc >= r_n);

    assign wr_box.cx  = i_cmd.cx;
    assign wr_box.cy  = i_cmd.cy;
    assign wr_box.w   = i_cmd.w;
    assign wr_box.h   = i_cmd.h;
    assign wr_box.trg = i_cmd.trg;

    // Shift after this contact: only a solid pair moves box A, along one axis
    assign upd_x = (r_solid && r_xle)  ? r_nsx : r_sx;
    assign upd_y = (r_solid && !r_xle) ? r_nsy : r_sy;

    assign abs_ox = (r_ox < 0) ? -r_ox : r_ox;
    assign abs_oy = (r_oy < 0) ? -r_oy : r_oy;

    // Sequencer next state and result drive
    always_comb begin
        n_state          = r_state;
        n_j              = r_j;
        n_n              = r_n;
        n_sx             = r_sx;
        n_sy             = r_sy;
        o_cmd_pop        = 1'b0;
        mem_we           = 1'b0;
        o_res_push       = 1'b0;
        rd_addr          = AW'(r_j);
        o_res.kind       = aabb_pkg::KIND_CONTACT;
        o_res.other_slot = aabb_pkg::SLOT_BITS'(r_j);
        o_res.solid      = r_solid;
        o_res.shift_x    = upd_x;
        o_res.shift_y    = upd_y;
        o_res.last       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                rd_addr = AW'(i_cmd.slot);
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_sx      = '0;
                    n_sy      = '0;
                    n_j       = NB'(i_cmd.slot);
                    n_n       = i_cmd.n;
                    case (i_cmd.kind)
                        aabb_pkg::CK_LOAD:    mem_we  = 1'b1;
                        aabb_pkg::CK_SCAN:    n_state = ST_ACAP;
                        aabb_pkg::CK_SUMMARY: n_state = ST_SUM;
                        default:              n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ACAP: begin
                rd_addr = AW'(j_inc);
                n_j     = j_inc;
                n_state = last_j ? ST_SUM : ST_SUMS;
            end
            ST_SUMS: n_state = ST_OVL;
            ST_OVL:  n_state = ST_ABS;
            ST_ABS:  n_state = ST_UPD;
            ST_UPD: begin
                rd_addr = AW'(j_inc);
                if (!r_hit) begin
                    n_j     = j_inc;
                    n_state = last_j ? ST_SUM : ST_SUMS;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_sx       = upd_x;
                    n_sy       = upd_y;
                    n_j        = j_inc;
                    n_state    = last_j ? ST_SUM : ST_SUMS;
                end
            end
            ST_SUM: begin
                o_res.kind       = aabb_pkg::KIND_SUMMARY;
                o_res.other_slot = '0;
                o_res.solid      = 1'b0;
                o_res.shift_x    = r_sx;
                o_res.shift_y    = r_sy;
                o_res.last       = 1'b1;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer state and run registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_j  <= n_j;
        r_n  <= n_n;
        r_sx <= n_sx;
        r_sy <= n_sy;
    end

    // Box memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(i_cmd.slot)] <= wr_box;
        end
        r_rd_box <= r_mem[rd_addr];
    end

    // Overlap datapath, one stage per state
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_ACAP: begin
                r_acx  <= EB'(r_rd_box.cx);
                r_acxw <= EB'(r_rd_box.cx) + EB'($signed({1'b0, r_rd_box.w}));
                r_acy  <= EB'(r_rd_box.cy);
                r_acyh <= EB'(r_rd_box.cy) + EB'($signed({1'b0, r_rd_box.h}));
                r_atrg <= r_rd_box.trg;
            end
            ST_SUMS: begin
                r_ax   <= r_acx + EB'(r_sx);
                r_axw  <= r_acxw + EB'(r_sx);
                r_ay   <= r_acy + EB'(r_sy);
                r_ayh  <= r_acyh + EB'(r_sy);
                r_bx   <= EB'(r_rd_box.cx);
                r_bxw  <= EB'(r_rd_box.cx) + EB'($signed({1'b0, r_rd_box.w}));
                r_by   <= EB'(r_rd_box.cy);
                r_byh  <= EB'(r_rd_box.cy) + EB'($signed({1'b0, r_rd_box.h}));
                r_btrg <= r_rd_box.trg;
            end
            ST_OVL: begin
                r_hit   <= (r_ax < r_bxw) && (r_axw > r_bx) &&
                           (r_ay < r_byh) && (r_ayh > r_by);
                r_solid <= !r_atrg && !r_btrg;
                r_ox    <= (r_ax < r_bx) ? (WB'(r_axw) - WB'(r_bx))
                                         : (WB'(r_ax) - WB'(r_bxw));
                r_oy    <= (r_ay < r_by) ? (WB'(r_ayh) - WB'(r_by))
                                         : (WB'(r_ay) - WB'(r_byh));
            end
            ST_ABS: begin
                // Ties go to x
                r_xle <= (abs_ox <= abs_oy);
                r_nsx <= aabb_pkg::sat_coord(WB'(r_sx) - r_ox);
                r_nsy <= aabb_pkg::sat_coord(WB'(r_sy) - r_oy);
            end
            default: begin
                r_hit <= r_hit;
            end
        endcase
    end

endmodule

FILE: hdl/aabb_collision_resolver_core.sv
// Top level of the 2D box collision resolver: config register, front, queues and back.
//
//  channel    | handshake               | payload
//  -----------+-------------------------+-------------------------------
//  item in    | push / full             | i_item   (aabb_pkg::t_item)
//  result out | pop / empty             | o_result (aabb_pkg::t_result)
//  config     | psel penable pwrite ... | active_count at paddr 0
//
//  A load item passes the front register and is written to box memory with the back
//  sequencer idle. A resolve item of slot s below n (n the effective active count)
//  goes through ST_ACAP, then ST_SUMS, ST_OVL, ST_ABS, ST_UPD for each later slot,
//  then ST_SUM; one with s not below n goes straight to ST_SUM. There are four steps
//  per scanned slot, set by the shift dependence from one compared slot to the next.
//  Reset is synchronous and clears the queues, sequencer and active_count; the
//  box memory is not cleared. A full result queue stalls the sequencer, and
//  full rises once the command queue and the front register are both taken.
`timescale 1ns / 1ps

module aabb_collision_resolver_core #(
    parameter int MAX_BOXES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  aabb_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output aabb_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [aabb_pkg::COUNT_BITS-1:0] r_active_count;
    logic                            cfg_wr;
    aabb_pkg::t_cmd                  fe_cmd, q_cmd;
    logic                            fe_push, cq_full, cq_empty, be_pop;
    aabb_pkg::t_result               be_res;
    logic                            be_push, rq_full;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready &
                    (paddr[2] == aabb_pkg::REG_ACTIVE_COUNT);
    assign prdata = (paddr[2] == aabb_pkg::REG_ACTIVE_COUNT) ? 32'(r_active_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= '0;
        end else if (cfg_wr) begin
            r_active_count <= pwdata[aabb_pkg::COUNT_BITS-1:0];
        end
    end

    aabb_fe #(
        .MAX_BOXES(MAX_BOXES)
    ) u_fe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_item         (i_item),
        .i_active_count (r_active_count),
        .o_cmd_push     (fe_push),
        .o_cmd          (fe_cmd),
        .i_cmd_full     (cq_full)
    );

    // Command queue between front and back
    aabb_fifo #(
        .WIDTH($bits(aabb_pkg::t_cmd)),
        .DEPTH(2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  (fe_cmd),
        .o_full  (cq_full),
        .i_pop   (be_pop),
        .o_data  (q_cmd),
        .o_empty (cq_empty)
    );

    aabb_be #(
        .MAX_BOXES(MAX_BOXES)
    ) u_be (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (cq_empty),
        .o_cmd_pop   (be_pop),
        .o_res       (be_res),
        .o_res_push  (be_push),
        .i_res_full  (rq_full)
    );

    // Result queue
    aabb_fifo #(
        .WIDTH($bits(aabb_pkg::t_result)),
        .DEPTH(2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (be_push),
        .i_data  (be_res),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

FILE: hdl/aabb_chk.sv
// Port-level checker of the collision resolver and its bind to the top level.
`timescale 1ns / 1ps

module aabb_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input aabb_pkg::t_result o_result,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [2:0]        paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    // Nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

    // Summary item shape
    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == aabb_pkg::KIND_SUMMARY) |->
        (o_result.last && o_result.other_slot == '0 && !o_result.solid))
        else $error("malformed summary item");

    // Contacts never close a run
    a_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == aabb_pkg::KIND_CONTACT) |-> !o_result.last)
        else $error("contact item marked last");

    // Written active_count reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready &&
         paddr[2] == aabb_pkg::REG_ACTIVE_COUNT) |=>
        ((paddr[2] != aabb_pkg::REG_ACTIVE_COUNT) ||
         prdata == 32'($past(pwdata[aabb_pkg::COUNT_BITS-1:0]))))
        else $error("active_count readback mismatch");

endmodule

bind aabb_collision_resolver_core aabb_chk u_aabb_chk (.*);
